[rtl/tsq_pkg.sv]
package tsq_pkg;

    // panel geometry
    localparam int PANEL_WIDTH  = 368;
    localparam int PANEL_HEIGHT = 448;
    localparam int VIEW_WIDTH   = 448;
    localparam int VIEW_HEIGHT  = 368;

    localparam int COORD_W = 10;
    localparam int RAW_W   = 12;

    // timing policy
    localparam logic [31:0] POLL_INTERVAL_MS   = 32'd20;
    localparam logic [31:0] FAIL_BACKOFF_MS    = 32'd250;
    localparam logic [31:0] RECOVER_BACKOFF_MS = 32'd1000;
    localparam logic [31:0] HANG_WINDOW_MS     = 32'd30000;
    localparam logic [2:0]  FAILS_TO_RECOVER   = 3'd5;
    localparam logic [1:0]  RELEASE_SAMPLES    = 2'd2;
    localparam logic [7:0]  MAX_POINTS         = 8'd4;
    localparam logic [7:0]  NIBBLE_MASK        = 8'h0F;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOUCH_ENABLED      = 2'd0,
        REG_CONTROLLER_VARIANT = 2'd1,
        REG_UI_ORIENTATION     = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ORIENT_PORTRAIT         = 2'd0,
        ORIENT_PORTRAIT_FLIP    = 2'd1,
        ORIENT_LANDSCAPE        = 2'd2,
        ORIENT_LANDSCAPE_FLIP   = 2'd3
    } t_orient;

    typedef enum logic [1:0] {
        PHASE_START = 2'd0,
        PHASE_MOVE  = 2'd1,
        PHASE_END   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        read_ok;
        logic [7:0]  pkt_byte0;
        logic [7:0]  pkt_byte1;
        logic [7:0]  pkt_byte2;
        logic [7:0]  pkt_byte3;
        logic [7:0]  pkt_byte4;
        logic [7:0]  pkt_byte5;
    } t_in;

    typedef struct packed {
        logic               poll_taken;
        logic               event_valid;
        logic               touched;
        logic [1:0]         phase;
        logic [COORD_W-1:0] event_x;
        logic [COORD_W-1:0] event_y;
        logic               recovery_request;
    } t_out;

    typedef struct packed {
        logic               variant;
        t_orient            orient;
    } t_coord_cfg;

endpackage

[rtl/tsq_coord.sv]
module tsq_coord (
    input  tsq_pkg::t_in                  i_item,
    input  tsq_pkg::t_coord_cfg           i_cfg,
    output logic [tsq_pkg::COORD_W-1:0]   o_x,
    output logic [tsq_pkg::COORD_W-1:0]   o_y
);
    import tsq_pkg::*;

    localparam logic [RAW_W-1:0] PW = RAW_W'(PANEL_WIDTH);
    localparam logic [RAW_W-1:0] PH = RAW_W'(PANEL_HEIGHT);
    localparam logic [RAW_W-1:0] VW = RAW_W'(VIEW_WIDTH);
    localparam logic [RAW_W-1:0] VH = RAW_W'(VIEW_HEIGHT);
    localparam logic [RAW_W-1:0] ONE = RAW_W'(1);

    function automatic logic [RAW_W-1:0] clamp_to(input logic [RAW_W-1:0] v,
                                                  input logic [RAW_W-1:0] lim);
        clamp_to = (v < lim) ? v : lim - ONE;
    endfunction

    logic [RAW_W-1:0] x_raw;
    logic [RAW_W-1:0] y_raw;
    logic [RAW_W-1:0] long_raw;
    logic [RAW_W-1:0] short_raw;
    logic [RAW_W-1:0] px;
    logic [RAW_W-1:0] py;
    logic [RAW_W-1:0] ex;
    logic [RAW_W-1:0] ey;

    // low nibble of the first byte on top of the second byte
    assign x_raw     = {i_item.pkt_byte1[3:0], i_item.pkt_byte2};
    assign y_raw     = {i_item.pkt_byte3[3:0], i_item.pkt_byte4};
    assign long_raw  = {i_item.pkt_byte2[3:0], i_item.pkt_byte3};
    assign short_raw = {i_item.pkt_byte4[3:0], i_item.pkt_byte5};

    always_comb begin
        if (i_cfg.variant) begin
            px = clamp_to(x_raw, PW);
            py = clamp_to(y_raw, PH);
        end else begin
            px = clamp_to(short_raw, PW);
            // long axis runs against physical y
            py = (long_raw >= PH) ? '0 : PH - ONE - long_raw;
        end
    end

    always_comb begin
        case (i_cfg.orient)
            ORIENT_PORTRAIT: begin
                ex = px;
                ey = py;
            end
            ORIENT_PORTRAIT_FLIP: begin
                ex = PW - ONE - px;
                ey = PH - ONE - py;
            end
            ORIENT_LANDSCAPE: begin
                ex = clamp_to(PH - ONE - py, VW);
                ey = clamp_to(px, VH);
            end
            default: begin
                ex = clamp_to(py, VW);
                ey = clamp_to(PW - ONE - px, VH);
            end
        endcase
    end

    assign o_x = ex[COORD_W-1:0];
    assign o_y = ey[COORD_W-1:0];

endmodule

[rtl/tsq_core.sv]
module tsq_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_fire,
    input  tsq_pkg::t_in                    i_item,
    input  logic [tsq_pkg::COORD_W-1:0]     i_x,
    input  logic [tsq_pkg::COORD_W-1:0]     i_y,
    output tsq_pkg::t_coord_cfg             o_coord_cfg,
    output tsq_pkg::t_out                   o_result
);
    import tsq_pkg::*;

    logic               r_enabled;
    logic               r_variant;
    t_orient            r_orient;
    logic               r_active,        n_active;
    logic [1:0]         r_empty_cnt,     n_empty_cnt;
    logic [2:0]         r_fail_cnt,      n_fail_cnt;
    logic [31:0]        r_backoff_until, n_backoff_until;
    logic [31:0]        r_last_poll,     n_last_poll;
    logic [31:0]        r_first_fail,    n_first_fail;
    logic [COORD_W-1:0] r_held_x,        n_held_x;
    logic [COORD_W-1:0] r_held_y,        n_held_y;

    logic        gate_ok;
    logic [31:0] streak_start;
    logic [2:0]  fail_inc;
    logic [1:0]  empty_inc;
    logic [7:0]  points;
    logic        no_points;
    t_out        res;

    assign o_coord_cfg.variant = r_variant;
    assign o_coord_cfg.orient  = r_orient;

    assign gate_ok = r_enabled && !(i_item.now_ms < r_backoff_until)
                     && ((i_item.now_ms - r_last_poll) >= POLL_INTERVAL_MS);
    assign streak_start = (r_first_fail == '0) ? i_item.now_ms : r_first_fail;
    assign fail_inc     = r_fail_cnt + 3'd1;
    assign empty_inc    = r_empty_cnt + 2'd1;
    assign points       = r_variant ? (i_item.pkt_byte0 & NIBBLE_MASK) : i_item.pkt_byte1;
    assign no_points    = (points == '0) || (points > MAX_POINTS);

    always_comb begin
        n_active        = r_active;
        n_empty_cnt     = r_empty_cnt;
        n_fail_cnt      = r_fail_cnt;
        n_backoff_until = r_backoff_until;
        n_last_poll     = r_last_poll;
        n_first_fail    = r_first_fail;
        n_held_x        = r_held_x;
        n_held_y        = r_held_y;
        res             = '0;

        if (gate_ok) begin
            n_last_poll    = i_item.now_ms;
            res.poll_taken = 1'b1;
            if (!i_item.read_ok) begin
                if (r_variant) begin
                    // hang window measured from the start of the failure streak
                    n_first_fail = streak_start;
                    if ((i_item.now_ms - streak_start) >= HANG_WINDOW_MS) begin
                        res.recovery_request = 1'b1;
                        n_first_fail         = i_item.now_ms;
                    end
                    n_backoff_until = i_item.now_ms + FAIL_BACKOFF_MS;
                end else begin
                    n_fail_cnt = fail_inc;
                    if (fail_inc >= FAILS_TO_RECOVER) begin
                        res.recovery_request = 1'b1;
                        n_fail_cnt           = '0;
                        n_backoff_until      = i_item.now_ms + RECOVER_BACKOFF_MS;
                    end else begin
                        n_backoff_until = i_item.now_ms + FAIL_BACKOFF_MS;
                    end
                end
                if (res.recovery_request) begin
                    n_active    = 1'b0;
                    n_empty_cnt = '0;
                end
            end else begin
                n_fail_cnt   = '0;
                n_first_fail = '0;
                if (no_points) begin
                    if (r_active) begin
                        n_empty_cnt = empty_inc;
                        if (empty_inc >= RELEASE_SAMPLES) begin
                            n_active        = 1'b0;
                            n_empty_cnt     = '0;
                            res.event_valid = 1'b1;
                            res.phase       = PHASE_END;
                            res.event_x     = r_held_x;
                            res.event_y     = r_held_y;
                        end
                    end
                end else begin
                    n_backoff_until = '0;
                    n_empty_cnt     = '0;
                    n_active        = 1'b1;
                    n_held_x        = i_x;
                    n_held_y        = i_y;
                    res.event_valid = 1'b1;
                    res.touched     = 1'b1;
                    res.phase       = r_active ? PHASE_MOVE : PHASE_START;
                    res.event_x     = i_x;
                    res.event_y     = i_y;
                end
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled       <= 1'b0;
            r_variant       <= 1'b0;
            r_orient        <= ORIENT_LANDSCAPE;
            r_active        <= 1'b0;
            r_empty_cnt     <= '0;
            r_fail_cnt      <= '0;
            r_backoff_until <= '0;
            r_last_poll     <= '0;
            r_first_fail    <= '0;
            r_held_x        <= '0;
            r_held_y        <= '0;
        end else begin
            if (i_fire) begin
                r_active        <= n_active;
                r_empty_cnt     <= n_empty_cnt;
                r_fail_cnt      <= n_fail_cnt;
                r_backoff_until <= n_backoff_until;
                r_last_poll     <= n_last_poll;
                r_first_fail    <= n_first_fail;
                r_held_x        <= n_held_x;
                r_held_y        <= n_held_y;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TOUCH_ENABLED:      r_enabled <= i_cfg_wdata[0];
                    REG_CONTROLLER_VARIANT: r_variant <= i_cfg_wdata[0];
                    REG_UI_ORIENTATION: begin
                        // a new orientation restarts polling, held point stays
                        if (t_orient'(i_cfg_wdata[1:0]) != r_orient) begin
                            r_orient        <= t_orient'(i_cfg_wdata[1:0]);
                            r_active        <= 1'b0;
                            r_empty_cnt     <= '0;
                            r_fail_cnt      <= '0;
                            r_backoff_until <= '0;
                            r_last_poll     <= '0;
                            r_first_fail    <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

[rtl/touch_sample_qualifier.sv]
// touch sample qualifier
// input channel (i_in_valid / o_in_ready / i_in_data) carries one poll opportunity:
// time in ms, read status and six packet bytes. output channel (o_out_valid /
// i_out_ready / o_out_data) returns exactly one result per opportunity: poll taken,
// optional start/move/end event with oriented coordinates, and a recovery request.
// registers are written through i_cfg_we / i_cfg_index / i_cfg_wdata; the user must do so
// only while idle, which the block does not enforce; index 0 enable, 1 controller variant,
// 2 orientation (a new value clears polling state).
// each item is held in the input register, then its result is loaded into the result register.
// throughput: one item per cycle while the receiver does not stall, set by the single
// compute step between the input register and the result register, which also updates
// the poll state. when the receiver stalls the result register holds; one more item is
// taken into the input register and then o_in_ready drops until the result is taken.
// reset clears the valid flags and all poll state, disables polling and selects landscape orientation.
module touch_sample_qualifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tsq_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tsq_pkg::t_out                   o_out_data
);
    import tsq_pkg::*;

    logic               r_in_valid;
    t_in                r_in;
    logic               r_out_valid;
    t_out               r_out;
    logic               advance;
    t_coord_cfg         coord_cfg;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    t_out               result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    tsq_coord u_coord (
        .i_item (r_in),
        .i_cfg  (coord_cfg),
        .o_x    (cx),
        .o_y    (cy)
    );

    tsq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (advance),
        .i_item      (r_in),
        .i_x         (cx),
        .i_y         (cy),
        .o_coord_cfg (coord_cfg),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
